FILE: design/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared constants, types and the prime table for the highly composite
// number search block.
// ----------------------------------------------------------------------------
`default_nettype none

package hcs_pkg;

    localparam int PRIME_LEVELS = 16;
    localparam int BOUND_BITS   = 63;

    localparam int NUM_W    = 63;
    localparam int COUNT_W  = 17;
    localparam int EXP_W    = 6;
    localparam int PRIME_W  = 6;
    localparam int LEVEL_W  = $clog2(PRIME_LEVELS);
    localparam int PRODX_W  = NUM_W + PRIME_W;
    localparam int CAND_W   = EXP_W + 1 + COUNT_W;

    localparam logic [EXP_W-1:0]   FIRST_CAP  = EXP_W'(63);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(131071);
    localparam logic [NUM_W-1:0]   BOUND_LIMIT =
        NUM_W'((65'd1 << BOUND_BITS) - 65'd1);
    localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(PRIME_LEVELS - 1);

    // Commands from the controller; at most one is high in a cycle.
    typedef struct packed {
        logic start;      // load bound, enter level 0
        logic mul;        // form product times prime of the current level
        logic push;       // grow this level, enter the next one
        logic leaf;       // grow the last level, merge its product
        logic pop;        // latch child result, step one level up
        logic merge_mul;  // form candidate divisor count
        logic merge_cmp;  // keep candidate if strictly greater
        logic finish;     // load the result register
    } hcs_cmd_t;

    typedef struct packed {
        logic can_grow;   // exponent below cap and product fits the bound
        logic last_level;
        logic root_level;
    } hcs_status_t;

    function automatic logic [PRIME_W-1:0] prime_at(input logic [3:0] idx);
        logic [PRIME_W-1:0] p;
        case (idx)
            4'd0:    p = 6'd2;
            4'd1:    p = 6'd3;
            4'd2:    p = 6'd5;
            4'd3:    p = 6'd7;
            4'd4:    p = 6'd11;
            4'd5:    p = 6'd13;
            4'd6:    p = 6'd17;
            4'd7:    p = 6'd19;
            4'd8:    p = 6'd23;
            4'd9:    p = 6'd29;
            4'd10:   p = 6'd31;
            4'd11:   p = 6'd37;
            4'd12:   p = 6'd41;
            4'd13:   p = 6'd43;
            4'd14:   p = 6'd47;
            default: p = 6'd53;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: design/hcs_dp.sv
// ----------------------------------------------------------------------------
// hcs_dp
// Search datapath: level stacks, product multiplier, divisor count merge
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcs_dp
    import hcs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire hcs_cmd_t           cmd,
    input  wire logic [NUM_W-1:0]   in_bound,
    output hcs_status_t             status,
    output logic [NUM_W-1:0]        out_number,
    output logic [COUNT_W-1:0]      out_count
);

    logic [LEVEL_W-1:0] lv_reg, lv_next;
    logic [NUM_W-1:0]   bound_reg;
    logic [PRODX_W-1:0] prodx_reg;
    logic [NUM_W-1:0]   child_num_reg;
    logic [COUNT_W-1:0] child_cnt_reg;
    logic [COUNT_W-1:0] cand_reg;
    logic [NUM_W-1:0]   out_number_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [EXP_W-1:0]   exp_stack_reg   [PRIME_LEVELS];
    logic [EXP_W-1:0]   cap_stack_reg   [PRIME_LEVELS];
    logic [NUM_W-1:0]   prod_stack_reg  [PRIME_LEVELS];
    logic [NUM_W-1:0]   best_stack_reg  [PRIME_LEVELS];
    logic [COUNT_W-1:0] count_stack_reg [PRIME_LEVELS];

    logic [EXP_W-1:0]   cur_exp;
    logic [EXP_W-1:0]   exp_inc;
    logic [CAND_W-1:0]  cand_full;
    logic [LEVEL_W-1:0] lv_up;

    assign cur_exp = exp_stack_reg[lv_reg];
    assign exp_inc = cur_exp + EXP_W'(1);
    assign lv_up   = lv_reg + LEVEL_W'(1);

    assign status.can_grow   = (cur_exp < cap_stack_reg[lv_reg]) &&
                               (prodx_reg <= {{PRIME_W{1'b0}}, bound_reg});
    assign status.last_level = (lv_reg == LAST_LEVEL);
    assign status.root_level = (lv_reg == '0);

    // (exponent + 1) * child count
    assign cand_full = CAND_W'({1'b0, cur_exp} + (EXP_W + 1)'(1)) *
                       CAND_W'(child_cnt_reg);

    always_comb begin
        lv_next = lv_reg;
        if (cmd.start) begin
            lv_next = '0;
        end else if (cmd.push) begin
            lv_next = lv_up;
        end else if (cmd.pop) begin
            lv_next = lv_reg - LEVEL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv_reg <= '0;
        end else begin
            lv_reg <= lv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            bound_reg <= (in_bound > BOUND_LIMIT) ? BOUND_LIMIT : in_bound;
            exp_stack_reg[0]   <= '0;
            cap_stack_reg[0]   <= FIRST_CAP;
            prod_stack_reg[0]  <= NUM_W'(1);
            best_stack_reg[0]  <= NUM_W'(1);
            count_stack_reg[0] <= COUNT_W'(1);
        end
        if (cmd.mul) begin
            prodx_reg <= prod_stack_reg[lv_reg] * prime_at(4'(lv_reg));
        end
        if (cmd.push || cmd.leaf) begin
            prod_stack_reg[lv_reg] <= prodx_reg[NUM_W-1:0];
            exp_stack_reg[lv_reg]  <= exp_inc;
        end
        if (cmd.push) begin
            exp_stack_reg[lv_up]   <= '0;
            cap_stack_reg[lv_up]   <= exp_inc;
            prod_stack_reg[lv_up]  <= prodx_reg[NUM_W-1:0];
            best_stack_reg[lv_up]  <= prodx_reg[NUM_W-1:0];
            count_stack_reg[lv_up] <= COUNT_W'(1);
        end
        if (cmd.leaf) begin
            child_num_reg <= prodx_reg[NUM_W-1:0];
            child_cnt_reg <= COUNT_W'(1);
        end
        if (cmd.pop) begin
            child_num_reg <= best_stack_reg[lv_reg];
            child_cnt_reg <= count_stack_reg[lv_reg];
        end
        if (cmd.merge_mul) begin
            cand_reg <= (cand_full > CAND_W'(COUNT_MAX)) ? COUNT_MAX
                                                         : cand_full[COUNT_W-1:0];
        end
        if (cmd.merge_cmp && (cand_reg > count_stack_reg[lv_reg])) begin
            best_stack_reg[lv_reg]  <= child_num_reg;
            count_stack_reg[lv_reg] <= cand_reg;
        end
        if (cmd.finish) begin
            out_number_reg <= best_stack_reg[0];
            out_count_reg  <= count_stack_reg[0];
        end
    end

    assign out_number = out_number_reg;
    assign out_count  = out_count_reg;

endmodule

`default_nettype wire

FILE: design/hcs_ctrl.sv
// ----------------------------------------------------------------------------
// hcs_ctrl
// Search sequencer: walks the depth first search one step at a time and
// owns both stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module hcs_ctrl
    import hcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire hcs_status_t status,
    output hcs_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_MUL       = 3'd1;
    localparam logic [2:0] ST_DECIDE    = 3'd2;
    localparam logic [2:0] ST_MERGE_MUL = 3'd3;
    localparam logic [2:0] ST_MERGE_CMP = 3'd4;
    localparam logic [2:0] ST_FINISH    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (status.can_grow && !status.last_level) begin
                    cmd.push   = 1'b1;
                    state_next = ST_MUL;
                end else if (status.can_grow) begin
                    cmd.leaf   = 1'b1;
                    state_next = ST_MERGE_MUL;
                end else if (!status.root_level) begin
                    cmd.pop    = 1'b1;
                    state_next = ST_MERGE_MUL;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_MERGE_MUL: begin
                cmd.merge_mul = 1'b1;
                state_next    = ST_MERGE_CMP;
            end
            ST_MERGE_CMP: begin
                cmd.merge_cmp = 1'b1;
                state_next    = ST_MUL;
            end
            ST_FINISH: begin
                // wait until the previous result has been taken
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/highly_composite_search.sv
// ----------------------------------------------------------------------------
// highly_composite_search
// Finds the number up to a bound with the most divisors.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries the upper bound; each transfer starts one search.
//   Master stream returns the best number and its divisor count, one
//   transfer per bound.
//   The search walks a depth first tree over exponents of the first sixteen
//   primes, one tree step at a time through a shared 63x6 multiplier and
//   bound compare. A step is a multiply, then a decide; a merge into the
//   parent is a 7x17 count multiply, then a compare. Each level entered
//   takes a grow step, an exhausted step and a merge, a product at the last
//   prime a step and a merge; the node count grows quickly with the bound.
//   s_tready is high only while no search is running.
//   The result sits in an output register; the next bound is accepted while
//   it waits. If the receiver stalls, a finished search holds until the
//   previous result has been transferred.
//   Synchronous active-low reset returns the sequencer to idle and drops
//   m_tvalid; the stacks need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module highly_composite_search
    import hcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [62:0] upper_bound, [63] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata    // [62:0] best_number, [79:63] divisor_count
);

    hcs_cmd_t           cmd;
    hcs_status_t        status;
    logic [NUM_W-1:0]   out_number;
    logic [COUNT_W-1:0] out_count;

    hcs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    hcs_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_bound   (s_tdata[NUM_W-1:0]),
        .status     (status),
        .out_number (out_number),
        .out_count  (out_count)
    );

    assign m_tdata = {out_count, out_number};

endmodule

`default_nettype wire
